>>> sv/cti_pkg.sv
package cti_pkg;

  // item kinds carried on in_tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // result kinds carried on out_tuser
  localparam logic [1:0] REGION_INTERP = 2'd0;
  localparam logic [1:0] REGION_FIRST  = 2'd1;
  localparam logic [1:0] REGION_LAST   = 2'd2;

  localparam int VAL_W     = 8;
  localparam int DIV_STEPS = VAL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic wr_point;
    logic start;
    logic take_last;
    logic go_first;
    logic take_first;
    logic scan_step;
    logic take_seg;
    logic mul;
    logic div_step;
    logic fin;
    logic load_out;
  } cti_cmd_t;

  typedef struct packed {
    logic hit_last;
    logic hit_first;
    logic seg_found;
    logic div_done;
    logic out_free;
  } cti_sts_t;

endpackage

>>> sv/cti_ctrl.sv
module cti_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic [0:0]         in_tuser,
  output logic               in_tready,
  input  cti_pkg::cti_sts_t  sts,
  output cti_pkg::cti_cmd_t  cmd
);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_RD_LAST   = 11'b000_0000_0010,
    ST_CHK_LAST  = 11'b000_0000_0100,
    ST_RD_FIRST  = 11'b000_0000_1000,
    ST_CHK_FIRST = 11'b000_0001_0000,
    ST_SCAN_RD   = 11'b000_0010_0000,
    ST_SCAN_CHK  = 11'b000_0100_0000,
    ST_MUL       = 11'b000_1000_0000,
    ST_DIV       = 11'b001_0000_0000,
    ST_FIN       = 11'b010_0000_0000,
    ST_DONE      = 11'b100_0000_0000
  } cti_state_t;

  cti_state_t state_r, state_nxt;
  logic       accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser[0] == cti_pkg::CMD_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = ST_RD_LAST;
          end else begin
            cmd.wr_point = 1'b1;
          end
        end
      end
      ST_RD_LAST:  state_nxt = ST_CHK_LAST;
      ST_CHK_LAST: begin
        if (sts.hit_last) begin
          cmd.take_last = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          cmd.go_first = 1'b1;
          state_nxt    = ST_RD_FIRST;
        end
      end
      ST_RD_FIRST: state_nxt = ST_CHK_FIRST;
      ST_CHK_FIRST: begin
        if (sts.hit_first) begin
          cmd.take_first = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          // first point becomes the lower end of the first candidate segment
          cmd.scan_step = 1'b1;
          state_nxt     = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (sts.seg_found) begin
          cmd.take_seg = 1'b1;
          state_nxt    = ST_MUL;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = ST_SCAN_RD;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/cti_datapath.sv
module cti_datapath #(
  parameter int MAX_POINTS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [8:0]         cfg_wr_data,
  input  logic [31:0]        in_tdata,
  input  cti_pkg::cti_cmd_t  cmd,
  output cti_pkg::cti_sts_t  sts,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,
  output logic [1:0]         out_tuser
);

  localparam int         IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [8:0] MAXP  = 9'(MAX_POINTS);

  logic [7:0] x_mem [MAX_POINTS];
  logic [7:0] y_mem [MAX_POINTS];

  logic [8:0]       pts_r;
  logic [8:0]       act_cnt;
  logic [8:0]       last9;
  logic [IDX_W-1:0] last_idx;

  logic [7:0]       in_index, in_x, in_y, in_q;
  logic [7:0]       q_r;
  logic [IDX_W-1:0] idx_r;
  logic [7:0]       x_rd_r, y_rd_r;
  logic [7:0]       xa_r, ya_r, xb_r, yb_r;

  logic [7:0]       dx, t_off, mag_dy;
  logic             dy_neg;
  logic [15:0]      prod;

  logic [7:0]                     rem_r, quo_r;
  logic [cti_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [8:0]                     rem_sh;
  logic                           rem_ge;
  logic [8:0]                     rem_sub;

  logic [9:0]       val_s;
  logic [7:0]       val_clamp;

  logic [7:0]       res_val_r;
  logic [IDX_W-1:0] res_seg_r;
  logic [1:0]       res_reg_r;

  logic             out_valid_r;
  logic [15:0]      out_data_r;
  logic [1:0]       out_user_r;

  assign in_index = in_tdata[7:0];
  assign in_x     = in_tdata[15:8];
  assign in_y     = in_tdata[23:16];
  assign in_q     = in_tdata[31:24];

  // zero acts as one point, anything above the table size as the full table
  always_comb begin
    if (pts_r == 9'd0) begin
      act_cnt = 9'd1;
    end else if (pts_r > MAXP) begin
      act_cnt = MAXP;
    end else begin
      act_cnt = pts_r;
    end
  end
  assign last9    = act_cnt - 9'd1;
  assign last_idx = last9[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= 9'd1;
    end else if (cfg_wr_en) begin
      pts_r <= cfg_wr_data;
    end
  end

  // point tables, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_point && ({1'b0, in_index} < MAXP)) begin
      x_mem[in_index[IDX_W-1:0]] <= in_x;
      y_mem[in_index[IDX_W-1:0]] <= in_y;
    end
    x_rd_r <= x_mem[idx_r];
    y_rd_r <= y_mem[idx_r];
  end

  assign dx     = xb_r - xa_r;
  assign t_off  = q_r - xa_r;
  assign dy_neg = (yb_r < ya_r);
  assign mag_dy = dy_neg ? (ya_r - yb_r) : (yb_r - ya_r);
  assign prod   = {8'd0, mag_dy} * {8'd0, t_off};

  // restoring division; the high byte of the product is already below dx
  assign rem_sh  = {rem_r, quo_r[7]};
  assign rem_ge  = (rem_sh >= {1'b0, dx});
  assign rem_sub = rem_sh - {1'b0, dx};

  always_comb begin
    if (dy_neg) begin
      val_s = {2'b00, ya_r} - {2'b00, quo_r} - {9'd0, (rem_r != 8'd0)};
    end else begin
      val_s = {2'b00, ya_r} + {2'b00, quo_r};
    end
    if (val_s[9]) begin
      val_clamp = 8'd0;
    end else if (val_s[8]) begin
      val_clamp = 8'hFF;
    end else begin
      val_clamp = val_s[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_r   <= in_q;
      idx_r <= last_idx;
    end else if (cmd.go_first) begin
      idx_r <= '0;
    end else if (cmd.scan_step) begin
      xa_r  <= x_rd_r;
      ya_r  <= y_rd_r;
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.take_seg) begin
      xb_r      <= x_rd_r;
      yb_r      <= y_rd_r;
      res_seg_r <= idx_r - 1'b1;
    end
    if (cmd.take_last) begin
      res_val_r <= y_rd_r;
      res_seg_r <= idx_r;
      res_reg_r <= cti_pkg::REGION_LAST;
    end
    if (cmd.take_first) begin
      res_val_r <= y_rd_r;
      res_seg_r <= '0;
      res_reg_r <= cti_pkg::REGION_FIRST;
    end
    if (cmd.mul) begin
      rem_r <= prod[15:8];
      quo_r <= prod[7:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sub[7:0] : rem_sh[7:0];
      quo_r <= {quo_r[6:0], rem_ge};
    end
    if (cmd.fin) begin
      res_val_r <= val_clamp;
      res_reg_r <= cti_pkg::REGION_INTERP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.mul) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // output register lets the next item in while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {8'(res_seg_r), res_val_r};
      out_user_r <= res_reg_r;
    end
  end

  assign sts.hit_last  = (x_rd_r <= q_r);
  assign sts.hit_first = (x_rd_r >= q_r);
  assign sts.seg_found = (xa_r <= q_r) && (x_rd_r > q_r);
  assign sts.div_done  = (cnt_r == cti_pkg::DIV_CNT_W'(cti_pkg::DIV_STEPS - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> sv/curve_table_interpolate.sv
// Piecewise linear curve lookup over a table of up to MAX_POINTS (x, y) byte points.
// A write item (in_tuser 0) stores one point and leaves the block ready for the next
// item; a query item (in_tuser 1) returns floor of the linear interpolation, or the
// first or last y when clamped. A query is checked against the last point, then the
// first point, and is otherwise interpolated in the lowest matching segment, found
// by a linear scan that reads the point tables one entry at a time, followed by a
// multiply state and an 8-step shift-subtract divider. The block takes the next item
// in the cycle after the result is loaded into the output register. points_in_use is
// written through cfg_wr_en/cfg_wr_data; the user must write it only while the block
// is idle, as the block itself does not enforce it.
module curve_table_interpolate #(
  parameter int MAX_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,   // points_in_use
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // point_index, point_x, point_y, query_x
  input  logic [0:0]  in_tuser,      // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // curve_value, segment_start
  output logic [1:0]  out_tuser      // region
);

  cti_pkg::cti_cmd_t cmd;
  cti_pkg::cti_sts_t sts;

  cti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cti_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

>>> sv/cti_checker.sv
module cti_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a result waiting on the output keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  // no result can appear the cycle after an item is taken into an idle block
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared one cycle after an item");

  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == cti_pkg::REGION_INTERP) ||
                   (out_tuser == cti_pkg::REGION_FIRST) ||
                   (out_tuser == cti_pkg::REGION_LAST))
    else $error("bad region code");

  // clamped to first always reports segment zero
  a_first_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == cti_pkg::REGION_FIRST) |-> out_tdata[15:8] == 8'd0)
    else $error("first clamp with nonzero segment");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind curve_table_interpolate cti_checker u_cti_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> tb/curve_table_interpolate_tb.sv
`timescale 1ns / 1ps

module curve_table_interpolate_tb;

  localparam int TABLE_DEPTH = 256;
  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    logic [7:0] value;
    logic [7:0] seg;
    logic [1:0] region;
    logic [7:0] query;
  } curve_answer_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [8:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  // shadow copy of the curve table and of points_in_use
  logic [7:0]    x_pts [TABLE_DEPTH];
  logic [7:0]    y_pts [TABLE_DEPTH];
  logic [8:0]    points_reg;
  curve_answer_t answers_due [$];

  int errors;
  int items_sent;
  bit calm;
  int send_gap_pct;
  int stall_pct;

  curve_table_interpolate uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int last_point();
    if (points_reg == 9'd0) return 0;
    if (points_reg > 9'(TABLE_DEPTH)) return TABLE_DEPTH - 1;
    return int'(points_reg) - 1;
  endfunction

  // update the shadow table or work out the curve value for one accepted item
  function automatic void track_item(input logic [0:0] cmd, input logic [31:0] data);
    curve_answer_t ans;
    int lp, seg, num, dx, frac;
    logic [7:0] q;
    bit found;
    if (cmd == cti_pkg::CMD_WRITE) begin
      x_pts[data[7:0]] = data[15:8];
      y_pts[data[7:0]] = data[23:16];
    end else begin
      q = data[31:24];
      lp = last_point();
      ans.query = q;
      // the last point is tested first, so one point in use clamps to last
      if (x_pts[lp] <= q) begin
        ans.value  = y_pts[lp];
        ans.seg    = 8'(lp);
        ans.region = cti_pkg::REGION_LAST;
      end else if (x_pts[0] >= q) begin
        ans.value  = y_pts[0];
        ans.seg    = 8'd0;
        ans.region = cti_pkg::REGION_FIRST;
      end else begin
        seg = 0;
        found = 1'b0;
        // lowest segment that brackets q, also for a table out of order
        for (int i = 0; i < lp; i++) begin
          if (!found && x_pts[i] <= q && x_pts[i + 1] > q) begin
            seg = i;
            found = 1'b1;
          end
        end
        dx  = int'(x_pts[seg + 1]) - int'(x_pts[seg]);
        num = (int'(y_pts[seg + 1]) - int'(y_pts[seg])) * (int'(q) - int'(x_pts[seg]));
        if (dx <= 0) dx = 1;
        // floor division, also for a falling segment
        frac = (num >= 0) ? num / dx : -((-num + dx - 1) / dx);
        ans.value  = 8'(int'(y_pts[seg]) + frac);
        ans.seg    = 8'(seg);
        ans.region = cti_pkg::REGION_INTERP;
      end
      answers_due.insert(answers_due.size(), ans);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want,
                                 input int query);
    $display("mismatch in %s for query x %0d: got %0d, want %0d", what, query, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    curve_answer_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0, 0);
      end else begin
        want = answers_due.pop_front();
        if (out_tdata[7:0] !== want.value)
          report_mismatch("curve_value", out_tdata[7:0], want.value, want.query);
        if (out_tdata[15:8] !== want.seg)
          report_mismatch("segment_start", out_tdata[15:8], want.seg, want.query);
        if (out_tuser !== want.region)
          report_mismatch("region", out_tuser, want.region, want.query);
      end
    end
  end

  // result side back-pressure in bursts
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(1, 100) <= stall_pct) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 12);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("curve_table_interpolate_tb NOT OK");
    $finish;
  end

  // called and left at a falling edge; tvalid stays high between back-to-back items
  task automatic send_item(input logic [0:0] cmd, input logic [31:0] data);
    int gap;
    if (!calm && $urandom_range(1, 100) <= send_gap_pct) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_item(cmd, data);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_point(input logic [7:0] idx, input logic [7:0] x, input logic [7:0] y);
    send_item(cti_pkg::CMD_WRITE, {8'($urandom), y, x, idx});
  endtask

  task automatic send_query(input logic [7:0] q);
    send_item(cti_pkg::CMD_QUERY, {q, 24'($urandom)});
  endtask

  // a write leaves no result behind, so the drain waits on after the last result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_points(input logic [8:0] count);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    points_reg = count;
  endtask

  function automatic logic [7:0] pick_y();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_query(input int lp);
    int r, k;
    r = $urandom_range(0, 7);
    k = $urandom_range(0, lp);
    if (r < 2) return x_pts[k];
    if (r == 2) return x_pts[k] + 8'd1;
    if (r == 3) return x_pts[k] - 8'd1;
    return 8'($urandom);
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 1;
    if (r == 1) return 2;
    if (r == 9) return $urandom_range(13, 40);
    return $urandom_range(3, 12);
  endfunction

  // fills entries 0..n-1: mostly rising x with repeats, sometimes flat or shuffled
  task automatic load_curve(input int n);
    int style, xv, step_max;
    style = $urandom_range(0, 9);
    step_max = 510 / n + 1;
    xv = (style == 9) ? 0 : $urandom_range(0, step_max);
    for (int i = 0; i < n; i++) begin
      if (style == 7) begin
        write_point(8'(i), 8'($urandom), pick_y());
      end else if (style == 8) begin
        write_point(8'(i), 8'(xv), pick_y());
      end else begin
        if (style == 9 && i == n - 1) xv = 255;
        write_point(8'(i), 8'(xv), pick_y());
        xv = xv + $urandom_range(0, step_max);
        if (xv > 255) xv = 255;
      end
    end
  endtask

  task automatic run_curve_phase(input int n, input int len);
    int pace;
    set_points(9'(n));
    pace = $urandom_range(0, 3);
    send_gap_pct = (pace == 0) ? 0 : pace * 20;
    pace = $urandom_range(0, 3);
    stall_pct = (pace == 0) ? 0 : pace * 15;
    load_curve(n);
    for (int j = 0; j < len; j++) begin
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1) == 1)
          write_point(8'($urandom_range(0, n - 1)), 8'($urandom), pick_y());
        else
          write_point(8'($urandom), 8'($urandom), pick_y());
      end else begin
        send_query(pick_query(last_point()));
      end
      if ($urandom_range(0, 60) == 0) drain_results();
    end
  endtask

  task automatic test_single_point();
    set_points(9'd1);
    write_point(8'd0, 8'd100, 8'd50);
    send_query(8'd0);
    send_query(8'd99);
    send_query(8'd100);
    send_query(8'd255);
  endtask

  task automatic test_two_points();
    set_points(9'd2);
    write_point(8'd1, 8'd200, 8'd10);
    send_query(8'd150);
    send_query(8'd151);
    send_query(8'd199);
    send_query(8'd200);
  endtask

  task automatic test_extreme_points();
    write_point(8'd0, 8'd0, 8'd255);
    write_point(8'd1, 8'd255, 8'd0);
    send_query(8'd0);
    send_query(8'd1);
    send_query(8'd254);
    send_query(8'd255);
  endtask

  // x falls between entries 1 and 2, the scan must take the lowest bracket
  task automatic test_unordered_table();
    set_points(9'd4);
    write_point(8'd0, 8'd10, 8'd0);
    write_point(8'd1, 8'd50, 8'd100);
    write_point(8'd2, 8'd20, 8'd200);
    write_point(8'd3, 8'd80, 8'd255);
    send_query(8'd15);
    send_query(8'd30);
    send_query(8'd60);
  endtask

  task automatic test_full_table();
    run_curve_phase(TABLE_DEPTH, 15);
  endtask

  task automatic test_random_curves();
    while (items_sent < 1150) run_curve_phase(pick_count(), $urandom_range(15, 50));
  endtask

  // every entry is loaded by now, so out of range counts are safe to query
  task automatic test_count_limits();
    set_points(9'd0);
    repeat (4) send_query(pick_query(last_point()));
    set_points(9'd511);
    repeat (4) send_query(pick_query(last_point()));
    set_points(9'd256);
    repeat (4) send_query(pick_query(last_point()));
  endtask

  task automatic test_streaming();
    calm = 1'b1;
    run_curve_phase(6, 100);
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 9'd0;
    in_tvalid    = 1'b0;
    in_tdata     = 32'd0;
    in_tuser     = cti_pkg::CMD_WRITE;
    points_reg   = 9'd1;
    errors       = 0;
    items_sent   = 0;
    calm         = 1'b0;
    send_gap_pct = 20;
    stall_pct    = 20;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_single_point();
    test_two_points();
    test_extreme_points();
    test_unordered_table();
    test_full_table();
    test_random_curves();
    test_count_limits();
    test_streaming();

    drain_results();
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("curve_table_interpolate_tb OK");
    end else begin
      $display("curve_table_interpolate_tb NOT OK");
    end
    $finish;
  end

endmodule
